>>> rtl/radix_digit_code_converter_macros.svh
// ---------------------------------------------------------------------------
// Radix digit code converter assertion macros
// Short forms for the concurrent checks of the converter. Each use expands
// to one labeled assertion, clocked on clock and disabled during reset.
// ---------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CODE_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CODE_CONVERTER_MACROS_SVH

// Check cons in the same cycle as ante.
`define RDCC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define RDCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/rdcc_pkg.sv
// ---------------------------------------------------------------------------
// Radix digit code converter package
// Field widths, digit-serial datapath sizes, the sequencer state type and
// the base clamp used by the converter.
// ---------------------------------------------------------------------------
package rdcc_pkg;

   // Port field widths
   localparam int VALUE_IN_W  = 30;
   localparam int BASE_W      = 4;
   localparam int VALUE_OUT_W = 64;

   // One decimal (or target) digit
   localparam int DIGIT_W = 4;

   // Base limits
   localparam logic [BASE_W-1:0] MIN_BASE  = 4'd2;
   localparam logic [BASE_W-1:0] DEC_RADIX = 4'd10;

   // Double dabble: enough decimal digits for any 30-bit value, two bits a cycle
   localparam int SRC_BCD_DIGITS = 10;
   localparam int DD_W           = SRC_BCD_DIGITS * DIGIT_W + VALUE_IN_W;
   localparam int DD_STEPS       = VALUE_IN_W / 2;

   // Evaluated value: nine decimal digits at most, so it stays below 2^30
   localparam int VAL_W = 30;

   // Serial divider: one byte of the dividend per cycle
   localparam int DIV_CHUNK_W = 8;
   localparam int DIV_STEPS   = (VAL_W + DIV_CHUNK_W - 1) / DIV_CHUNK_W;
   localparam int DIV_W       = DIV_STEPS * DIV_CHUNK_W;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

   // Sequencer states
   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_DABBLE = 6'b000010,
      ST_HORNER = 6'b000100,
      ST_DIVIDE = 6'b001000,
      ST_PACK   = 6'b010000,
      ST_FLUSH  = 6'b100000
   } state_type;

   // Force a base into 2..10
   function automatic logic [BASE_W-1:0] clamp_base(input logic [BASE_W-1:0] b);
      logic [BASE_W-1:0] r;
      priority if (b < MIN_BASE) begin
         r = MIN_BASE;
      end else if (b > DEC_RADIX) begin
         r = DEC_RADIX;
      end else begin
         r = b;
      end
      return r;
   endfunction

endpackage

>>> rtl/radix_digit_code_converter.sv
// ---------------------------------------------------------------------------
// Radix digit code converter
// Reads a number whose decimal digits are digits of a source base and writes
// it again as target-base digits, one per decimal position of the result.
// ---------------------------------------------------------------------------
// Usage:
//   A beat on the req_ channel carries value_in, from_base and to_base; it
//   is taken when req_valid is high and req_stall is low. One beat on the
//   rsp_ channel answers it with value_out and overflow.
//   Bases outside 2..10 are clamped; equal bases pass the low IN_DIGITS
//   digits through. overflow flags a result longer than OUT_DIGITS digits.
//   A beat passes through the double dabble, the Horner fold of the kept
//   source digits, the serial divider that peels the target digits, the
//   packing of those digits and the flush into the output register. While
//   the value is still nonzero each target digit takes a divider pass;
//   once it is zero the digit comes out at once. The serial divider, one
//   byte of dividend a cycle, is the slowest step. One beat is in work at a
//   time; req_stall is high until the result is in the output register, and
//   the next beat may be taken while that result still waits on rsp_stall.
//   Reset (synchronous) drops any beat in work and any waiting result.
// ---------------------------------------------------------------------------
module radix_digit_code_converter
   import rdcc_pkg::*;
#(
   parameter int IN_DIGITS  = 9,
   parameter int OUT_DIGITS = 19
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_IN_W-1:0]  req_value_in,
   input  logic [BASE_W-1:0]      req_from_base,
   input  logic [BASE_W-1:0]      req_to_base,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [VALUE_OUT_W-1:0] rsp_value_out,
   output logic                   rsp_overflow
);

   localparam int RES_W    = OUT_DIGITS * DIGIT_W;
   localparam int KEEP_MSB = VALUE_IN_W + IN_DIGITS * DIGIT_W - 1;
   localparam int CNT_MAX  = (DD_STEPS > IN_DIGITS) ?
                             ((DD_STEPS > OUT_DIGITS) ? DD_STEPS : OUT_DIGITS) :
                             ((IN_DIGITS > OUT_DIGITS) ? IN_DIGITS : OUT_DIGITS);
   localparam int CNT_W    = $clog2(CNT_MAX);

   state_type                state_ff, state_in;
   logic [DD_W-1:0]          dd_ff, dd_in;
   logic [BASE_W-1:0]        hb_ff, hb_in;
   logic [BASE_W-1:0]        eb_ff, eb_in;
   logic [DIV_W-1:0]         val_ff, val_in;
   logic [DIGIT_W-1:0]       rem_ff, rem_in;
   logic [DIV_CNT_W-1:0]     chunk_ff, chunk_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [RES_W-1:0]         res_ff, res_in;
   logic                     ovf_ff, ovf_in;
   logic [VALUE_OUT_W-1:0]   acc_ff, acc_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_OUT_W-1:0]   rsp_value_out_ff, rsp_value_out_in;
   logic                     rsp_overflow_ff, rsp_overflow_in;

   logic [BASE_W-1:0]        fb_clamped;
   logic [BASE_W-1:0]        tb_clamped;
   logic [DIGIT_W-1:0]       horner_digit;
   logic [VAL_W+BASE_W-1:0]  horner_sum;
   logic [DIGIT_W-1:0]       div_rem_start;
   logic [DIGIT_W-1:0]       div_rem;
   logic [DIV_CHUNK_W-1:0]   div_q;
   logic [DIGIT_W-1:0]       pack_digit;
   logic                     div_zero;
   logic                     digit_done;
   logic [DIGIT_W-1:0]       new_digit;
   logic                     out_free;

   // One double-dabble bit: add 3 to each digit of 5 or more, then shift left
   function automatic logic [DD_W-1:0] dabble(input logic [DD_W-1:0] x);
      logic [DD_W-1:0] y;
      y = x;
      for (int k = 0; k < SRC_BCD_DIGITS; k++) begin
         if (y[VALUE_IN_W + k * DIGIT_W +: DIGIT_W] >= 4'd5) begin
            y[VALUE_IN_W + k * DIGIT_W +: DIGIT_W] =
               y[VALUE_IN_W + k * DIGIT_W +: DIGIT_W] + 4'd3;
         end
      end
      return {y[DD_W-2:0], 1'b0};
   endfunction

   // Restoring division of one dividend byte by a small base
   function automatic logic [DIGIT_W+DIV_CHUNK_W-1:0] div_chunk(
      input logic [DIGIT_W-1:0]     r_start,
      input logic [DIV_CHUNK_W-1:0] bits,
      input logic [BASE_W-1:0]      b
   );
      logic [DIGIT_W:0]       r;
      logic [DIV_CHUNK_W-1:0] q;
      r = {1'b0, r_start};
      q = '0;
      for (int k = DIV_CHUNK_W - 1; k >= 0; k--) begin
         r = {r[DIGIT_W-1:0], bits[k]};
         if (r >= {1'b0, b}) begin
            r    = r - {1'b0, b};
            q[k] = 1'b1;
         end
      end
      return {r[DIGIT_W-1:0], q};
   endfunction

   // Datapath taps
   assign fb_clamped    = clamp_base(req_from_base);
   assign tb_clamped    = clamp_base(req_to_base);
   assign horner_digit  = dd_ff[KEEP_MSB -: DIGIT_W];
   assign horner_sum    = (VAL_W+BASE_W)'(val_ff[VAL_W-1:0]) * (VAL_W+BASE_W)'(hb_ff)
                          + (VAL_W+BASE_W)'(horner_digit);
   assign div_rem_start = (chunk_ff == '0) ? '0 : rem_ff;
   assign {div_rem, div_q} = div_chunk(div_rem_start, val_ff[DIV_W-1 -: DIV_CHUNK_W], eb_ff);
   assign div_zero      = (chunk_ff == '0) && (val_ff == '0);
   assign pack_digit    = res_ff[RES_W-1 -: DIGIT_W];
   assign out_free      = !rsp_valid_ff || !rsp_stall;

   // Sequencer and next-state datapath
   always_comb begin
      state_in         = state_ff;
      dd_in            = dd_ff;
      hb_in            = hb_ff;
      eb_in            = eb_ff;
      val_in           = val_ff;
      rem_in           = rem_ff;
      chunk_in         = chunk_ff;
      cnt_in           = cnt_ff;
      res_in           = res_ff;
      ovf_in           = ovf_ff;
      acc_in           = acc_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_value_out_in = rsp_value_out_ff;
      rsp_overflow_in  = rsp_overflow_ff;
      digit_done       = 1'b0;
      new_digit        = '0;

      // Drop the result once the receiver takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               dd_in  = {{(SRC_BCD_DIGITS*DIGIT_W){1'b0}}, req_value_in};
               cnt_in = '0;
               if (fb_clamped == tb_clamped) begin
                  hb_in = DEC_RADIX;
                  eb_in = DEC_RADIX;
               end else begin
                  hb_in = fb_clamped;
                  eb_in = tb_clamped;
               end
               state_in = ST_DABBLE;
            end
         end
         ST_DABBLE: begin
            // Two binary bits into the decimal digits per cycle
            dd_in  = dabble(dabble(dd_ff));
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DD_STEPS - 1)) begin
               cnt_in   = '0;
               val_in   = '0;
               state_in = ST_HORNER;
            end
         end
         ST_HORNER: begin
            // Fold in the kept source digits, most significant first
            val_in = DIV_W'(horner_sum[VAL_W-1:0]);
            dd_in  = dd_ff << DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(IN_DIGITS - 1)) begin
               cnt_in   = '0;
               chunk_in = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // Peel target digits; a zero value yields a zero digit at once
            if (div_zero) begin
               digit_done = 1'b1;
            end else begin
               val_in   = {val_ff[DIV_W-DIV_CHUNK_W-1:0], div_q};
               rem_in   = div_rem;
               chunk_in = chunk_ff + 1'b1;
               if (chunk_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
                  chunk_in   = '0;
                  new_digit  = div_rem;
                  digit_done = 1'b1;
               end
            end
            if (digit_done) begin
               res_in = RES_W'({new_digit, res_ff} >> DIGIT_W);
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(OUT_DIGITS - 1)) begin
                  ovf_in   = (val_in != '0);
                  cnt_in   = '0;
                  acc_in   = '0;
                  state_in = ST_PACK;
               end
            end
         end
         ST_PACK: begin
            // Weigh the digits by powers of ten, most significant first
            acc_in = (acc_ff << 3) + (acc_ff << 1) + VALUE_OUT_W'(pack_digit);
            res_in = res_ff << DIGIT_W;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(OUT_DIGITS - 1)) begin
               cnt_in   = '0;
               state_in = ST_FLUSH;
            end
         end
         ST_FLUSH: begin
            // Hold until the output register is free
            if (out_free) begin
               rsp_valid_in     = 1'b1;
               rsp_value_out_in = acc_ff;
               rsp_overflow_in  = ovf_ff;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      dd_ff            <= dd_in;
      hb_ff            <= hb_in;
      eb_ff            <= eb_in;
      val_ff           <= val_in;
      rem_ff           <= rem_in;
      chunk_ff         <= chunk_in;
      cnt_ff           <= cnt_in;
      res_ff           <= res_in;
      ovf_ff           <= ovf_in;
      acc_ff           <= acc_in;
      rsp_value_out_ff <= rsp_value_out_in;
      rsp_overflow_ff  <= rsp_overflow_in;
   end

   assign req_stall     = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_value_out = rsp_value_out_ff;
   assign rsp_overflow  = rsp_overflow_ff;

endmodule

>>> rtl/rdcc_checker.sv
// ---------------------------------------------------------------------------
// Radix digit code converter checker
// Port-level checks of the converter's sequencing, bound to the top level.
// ---------------------------------------------------------------------------
`include "radix_digit_code_converter_macros.svh"

module rdcc_checker
   import rdcc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [VALUE_OUT_W-1:0] rsp_value_out,
   input logic                   rsp_overflow
);

   // A taken beat keeps the block busy the next cycle
   `RDCC_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall,
      "converter not busy after taking a beat")

   // A result only appears at the end of work
   `RDCC_ASSERT_NOW(a_result_from_work, $rose(rsp_valid), $past(req_stall),
      "result appeared while idle")

   // Going idle means a result was just loaded
   `RDCC_ASSERT_NOW(a_idle_with_result, $fell(req_stall) && !$past(reset), rsp_valid,
      "converter went idle without a result")

   // Hold a stalled result
   `RDCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_value_out) && $stable(rsp_overflow),
      "stalled result changed")

endmodule

bind radix_digit_code_converter rdcc_checker u_rdcc_checker (.*);

>>> bench/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Radix digit code converter testbench
// Drives conversion beats through the req_ channel, predicts every answer
// with a behavioral digit converter and checks each rsp_ beat against it.
// Random idling on both sides, one long receiver hold-off and an idle-free
// stretch exercise the handshake.
// ---------------------------------------------------------------------------
module tb
   import rdcc_pkg::*;
();

   localparam int IN_DIGITS      = 9;
   localparam int OUT_DIGITS     = 19;
   localparam int RANDOM_ITEMS   = 850;
   localparam int SQUEEZE_CYCLES = 600;
   localparam int TAIL_CYCLES    = 130;
   localparam int IDLE_PCT       = 23;

   // One expected answer, with the beat that caused it
   typedef struct packed {
      logic [VALUE_IN_W-1:0]  value_in;
      logic [BASE_W-1:0]      from_base;
      logic [BASE_W-1:0]      to_base;
      logic [VALUE_OUT_W-1:0] value_out;
      logic                   overflow;
   } conversion_type;

   class conversion_board_type;
      conversion_type awaited_q[$];
      int unsigned errors;
      int unsigned checked;
      int unsigned overflows;
      int unsigned passthrough;

      function new();
         errors      = 0;
         checked     = 0;
         overflows   = 0;
         passthrough = 0;
      endfunction

      // Force a base into 2..10
      function logic [63:0] limit_radix(logic [BASE_W-1:0] b);
         if (b < MIN_BASE) begin
            return 64'(MIN_BASE);
         end
         if (b > DEC_RADIX) begin
            return 64'(DEC_RADIX);
         end
         return 64'(b);
      endfunction

      // Evaluate the source digits, then re-emit them in the target base
      function conversion_type convert_digits(logic [VALUE_IN_W-1:0] raw,
                                              logic [BASE_W-1:0] from_radix,
                                              logic [BASE_W-1:0] to_radix);
         logic [63:0] src, fb, tgt, kept, amount, place, dec_place, emit, res, d;
         conversion_type r;
         src       = 64'(raw);
         fb        = limit_radix(from_radix);
         tgt       = limit_radix(to_radix);
         kept      = 0;
         amount    = 0;
         place     = 1;
         dec_place = 1;
         for (int i = 0; i < IN_DIGITS; i++) begin
            d         = src % 10;
            src       = src / 10;
            kept      = kept + d * dec_place;
            amount    = amount + d * place;
            dec_place = dec_place * 10;
            place     = place * fb;
         end
         // equal bases keep the masked decimal digits as they are
         if (fb == tgt) begin
            amount = kept;
            emit   = 10;
         end else begin
            emit = tgt;
         end
         res   = 0;
         place = 1;
         for (int i = 0; i < OUT_DIGITS; i++) begin
            d      = amount % emit;
            amount = amount / emit;
            res    = res + d * place;
            place  = place * 10;
         end
         r.value_in  = raw;
         r.from_base = from_radix;
         r.to_base   = to_radix;
         r.value_out = res;
         r.overflow  = (amount != 0);
         return r;
      endfunction

      function void note_input(logic [VALUE_IN_W-1:0] raw,
                               logic [BASE_W-1:0] from_radix,
                               logic [BASE_W-1:0] to_radix);
         conversion_type r;
         r = convert_digits(raw, from_radix, to_radix);
         if (r.overflow) begin
            overflows++;
         end
         if (limit_radix(from_radix) == limit_radix(to_radix)) begin
            passthrough++;
         end
         awaited_q.push_back(r);
      endfunction

      function void check_result(logic [VALUE_OUT_W-1:0] value_out, logic overflow);
         conversion_type want;
         if (awaited_q.size() == 0) begin
            $display("%0t: result with nothing awaited: value_out=%0d overflow=%0b",
                     $time, value_out, overflow);
            errors++;
            return;
         end
         want = awaited_q.pop_front();
         checked++;
         if (want.value_out !== value_out) begin
            $display("%0t: value_out for %0d (%0d->%0d): expected %0d, actual %0d",
                     $time, want.value_in, want.from_base, want.to_base,
                     want.value_out, value_out);
            errors++;
         end
         if (want.overflow !== overflow) begin
            $display("%0t: overflow for %0d (%0d->%0d): expected %0b, actual %0b",
                     $time, want.value_in, want.from_base, want.to_base,
                     want.overflow, overflow);
            errors++;
         end
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic [VALUE_IN_W-1:0]  req_value_in;
   logic [BASE_W-1:0]      req_from_base;
   logic [BASE_W-1:0]      req_to_base;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [VALUE_OUT_W-1:0] rsp_value_out;
   logic                   rsp_overflow;

   conversion_board_type board;
   bit                   idle_on     = 1'b1;
   bit                   squeeze_req = 1'b0;
   int unsigned          items_sent  = 0;

   radix_digit_code_converter #(
      .IN_DIGITS  (IN_DIGITS),
      .OUT_DIGITS (OUT_DIGITS)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_value_in  (req_value_in),
      .req_from_base (req_from_base),
      .req_to_base   (req_to_base),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_value_out (rsp_value_out),
      .rsp_overflow  (rsp_overflow)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Offer one beat, optionally after an idle gap; hold it until taken
   task automatic send_item(input logic [VALUE_IN_W-1:0] raw,
                            input logic [BASE_W-1:0] from_radix,
                            input logic [BASE_W-1:0] to_radix);
      int gap;
      gap = 0;
      if (idle_on && $urandom_range(99, 0) < IDLE_PCT) begin
         gap = $urandom_range(40, 1);
      end
      repeat (gap) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_value_in  <= raw;
      req_from_base <= from_radix;
      req_to_base   <= to_radix;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      board.note_input(raw, from_radix, to_radix);
      items_sent++;
      @(negedge clock);
   endtask

   // Digits all below the source base, random length
   task automatic send_wellformed();
      logic [VALUE_IN_W-1:0] v;
      int unsigned           fb;
      int unsigned           count;
      fb    = $urandom_range(10, 2);
      count = $urandom_range(IN_DIGITS, 1);
      v     = '0;
      for (int k = 0; k < count; k++) begin
         v = VALUE_IN_W'(v * 10 + $urandom_range(fb - 1, 0));
      end
      send_item(v, BASE_W'(fb), BASE_W'($urandom_range(10, 2)));
   endtask

   task automatic send_random();
      int unsigned           pick;
      logic [BASE_W-1:0]     fb;
      logic [VALUE_IN_W-1:0] v;
      pick = $urandom_range(99, 0);
      if (pick < 50) begin
         send_wellformed();
      end else if (pick < 70) begin
         send_item(VALUE_IN_W'($urandom_range(999999999, 0)),
                   BASE_W'($urandom_range(10, 2)), BASE_W'($urandom_range(10, 2)));
      end else if (pick < 85) begin
         // full-width value and unclamped bases
         v = VALUE_IN_W'($urandom());
         send_item(v, BASE_W'($urandom()), BASE_W'($urandom()));
      end else begin
         fb = BASE_W'($urandom_range(10, 2));
         send_item(VALUE_IN_W'($urandom_range(1000, 0)), fb,
                   ($urandom_range(1, 0) == 1) ? fb : BASE_W'($urandom_range(10, 2)));
      end
   endtask

   // Receiver: random stall, plus one long hold-off on request
   initial begin : rsp_side
      int hold_left;
      bit squeeze_done;
      hold_left    = 0;
      squeeze_done = 1'b0;
      rsp_stall    = 1'b0;
      forever begin
         @(negedge clock);
         if (squeeze_req && !squeeze_done) begin
            squeeze_done = 1'b1;
            hold_left    = SQUEEZE_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= idle_on && ($urandom_range(99, 0) < IDLE_PCT);
         end
      end
   end

   // Check every accepted result beat
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         board.check_result(rsp_value_out, rsp_overflow);
      end
   end

   initial begin : watchdog
      #2000000;
      $display("Some tests failed");
      $finish;
   end

   initial begin : stimulus
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value_in  = '0;
      req_from_base = '0;
      req_to_base   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: zero, extremes, clamped bases, equal bases, digit-count edges
      send_item(30'd0, 4'd10, 4'd2);
      send_item(30'd999999999, 4'd10, 4'd2);
      send_item(30'd999999999, 4'd10, 4'd10);
      send_item(30'h3FFFFFFF, 4'd10, 4'd9);
      send_item(30'd1000000000, 4'd10, 4'd5);
      send_item(30'd536870912, 4'd10, 4'd7);
      send_item(30'd111111111, 4'd2, 4'd10);
      send_item(30'd777777777, 4'd8, 4'd2);
      send_item(30'd123456789, 4'd10, 4'd3);
      send_item(30'd888888888, 4'd9, 4'd10);
      send_item(30'd987654321, 4'd10, 4'd9);
      send_item(30'd1, 4'd2, 4'd10);
      send_item(30'd524287, 4'd10, 4'd2);
      send_item(30'd524288, 4'd10, 4'd2);
      send_item(30'd101, 4'd0, 4'd15);
      send_item(30'd1010101010, 4'd0, 4'd1);
      send_item(30'd345, 4'd1, 4'd11);
      send_item(30'd999, 4'd14, 4'd0);
      send_item(30'd42, 4'd12, 4'd13);
      send_item(30'd999999999, 4'd15, 4'd8);
      send_item(30'd99, 4'd3, 4'd4);
      send_item(30'd555555555, 4'd6, 4'd2);

      // Random: one long receiver hold-off, then an idle-free stretch
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 300) begin
            squeeze_req = 1'b1;
         end
         idle_on = !(n >= 500 && n < 650);
         send_random();
      end
      idle_on   = 1'b1;
      req_valid <= 1'b0;

      // Drain, then wait out a tail for stray beats
      while (board.awaited_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d conversions, checked %0d results (%0d overflowing, %0d equal-base).",
               items_sent, board.checked, board.overflows, board.passthrough);
      if (board.errors == 0 && board.awaited_q.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
